FILE: rtl/mdd_pkg.sv
`timescale 1ns / 1ps
package mdd_pkg;
	localparam int SENDER_SLOTS   = 4;
	localparam int MESSAGE_SLOTS  = 16;
	localparam int KEY_WIDTH      = 64;
	localparam int LIFETIME_RESET = 20000;

	localparam int SW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
	localparam int EW = $clog2(MESSAGE_SLOTS);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SENDER = 7'b0000010,
		S_TAKE   = 7'b0000100,
		S_SWEEP  = 7'b0001000,
		S_MASK   = 7'b0010000,
		S_DROP   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// compare result for one stored message
	typedef struct packed {
		logic id_eq;
		logic expired;
	} cmp_t;

	function automatic logic [EW-1:0] lowest_entry(input logic [MESSAGE_SLOTS-1:0] v);
		logic [EW-1:0] r;
		r = '0;
		for (int i = MESSAGE_SLOTS - 1; i >= 0; i--)
			if (v[i]) r = EW'(i);
		return r;
	endfunction

	function automatic logic [SW-1:0] lowest_sender(input logic [SENDER_SLOTS-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int i = SENDER_SLOTS - 1; i >= 0; i--)
			if (v[i]) r = SW'(i);
		return r;
	endfunction
endpackage

FILE: rtl/mdd_entry_store.sv
`timescale 1ns / 1ps
module mdd_entry_store (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [mdd_pkg::EW-1:0]  wr_addr,
	input  logic [15:0]             wr_id,
	input  logic [31:0]             wr_ts,
	input  logic                    rd_en,
	input  logic [mdd_pkg::EW-1:0]  rd_addr,
	input  logic [15:0]             cmp_id,
	input  logic [31:0]             now,
	input  logic [30:0]             lifetime,
	output mdd_pkg::cmp_t           cmp
);
	import mdd_pkg::*;

	logic [47:0] mem [MESSAGE_SLOTS];
	logic [47:0] rd_q;
	logic [31:0] age;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_id, wr_ts};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// wrapping age against lifetime
	assign age         = now - rd_q[31:0];
	assign cmp.id_eq   = (rd_q[47:32] == cmp_id);
	assign cmp.expired = (age > {1'b0, lifetime});
endmodule

FILE: rtl/message_duplicate_detector.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       operation, sender_key, message_id, now_ms
// out       output     out_valid / out_ready     duplicate
// config    input      lifetime_we               lifetime_ms
//
// a check sweeps the entry memory with one read per slot through its registered read port,
// then a mask step, then removes each stale match in turn before the result
// a record does sender placement, an eviction of a sender's entries one per cycle, and on a
// full table a purge sweep over the memory, then removal of the oldest entry if still full
// in_ready comes back in the same cycle as the result is loaded; a full output register holds
// the result until out_ready
// reset clears all valid bits and ranks at once; no clearing pass is needed
// the output register frees the input side while a result waits for out_ready
module message_duplicate_detector (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  lifetime_we,
	input  logic [30:0]           lifetime_ms,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [63:0]           sender_key,
	input  logic [15:0]           message_id,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  duplicate
);
	import mdd_pkg::*;

	state_t state_q, ret_q;
	logic [30:0] lifetime_q;

	logic                 op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [15:0]          mid_q;
	logic [31:0]          now_q;
	logic [SENDER_SLOTS-1:0] hit_q;
	logic [SW-1:0]        sidx_q;
	logic                 purged_q;
	logic                 dup_q;

	logic [KEY_WIDTH-1:0] skey_q [SENDER_SLOTS];
	logic [SENDER_SLOTS-1:0] svalid_q;
	logic [SW-1:0]        srank_q [SENDER_SLOTS];

	logic [MESSAGE_SLOTS-1:0] evalid_q;
	logic [SW-1:0]        eslot_q [MESSAGE_SLOTS];
	logic [EW-1:0]        erank_q [MESSAGE_SLOTS];

	logic [EW-1:0]        rd_cnt_q;
	logic                 issue_q;
	logic                 vld_s1;
	logic [EW-1:0]        idx_s1;
	logic [MESSAGE_SLOTS-1:0] live_q, stale_q, liverank_q, mask_q;

	logic                 out_valid_q, out_dup_q;

	cmp_t                 cmp;
	logic                 accept;
	logic [KEY_WIDTH-1:0] in_key;
	logic [SENDER_SLOTS-1:0] in_hit;
	logic [SENDER_SLOTS-1:0] has_entry, cand, candrank;
	logic [SW-1:0]        victim, free_s, hit_s;
	logic [SW-1:0]        vrank;
	logic [SW:0]          scount;
	logic [EW:0]          ecount;
	logic [EW-1:0]        free_e, de, thr;
	logic                 match;
	logic                 snd_wr, ent_wr;
	logic [SW-1:0]        snd_widx;

	assign in_key   = sender_key[KEY_WIDTH-1:0];
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign duplicate = out_dup_q;

	always_comb begin
		for (int s = 0; s < SENDER_SLOTS; s++)
			in_hit[s] = svalid_q[s] && (skey_q[s] == in_key);
	end

	// sender bookkeeping
	always_comb begin
		has_entry = '0;
		scount = '0;
		for (int j = 0; j < MESSAGE_SLOTS; j++)
			if (evalid_q[j]) has_entry[eslot_q[j]] = 1'b1;
		for (int s = 0; s < SENDER_SLOTS; s++)
			scount = scount + (SW+1)'(svalid_q[s]);
		cand = svalid_q & ~has_entry;
		candrank = '0;
		for (int s = 0; s < SENDER_SLOTS; s++)
			if (cand[s]) candrank[srank_q[s]] = 1'b1;
		// oldest sender without entries, else the oldest sender
		vrank = (|cand) ? lowest_sender(candrank) : '0;
		victim = '0;
		for (int s = SENDER_SLOTS - 1; s >= 0; s--)
			if (svalid_q[s] && srank_q[s] == vrank) victim = SW'(s);
		free_s = lowest_sender(~svalid_q);
		hit_s  = lowest_sender(hit_q);
	end

	always_comb begin
		ecount = '0;
		for (int j = 0; j < MESSAGE_SLOTS; j++)
			ecount = ecount + (EW+1)'(evalid_q[j]);
		free_e = lowest_entry(~evalid_q);
		de     = lowest_entry(mask_q);
		thr    = lowest_entry(liverank_q);
		match  = evalid_q[idx_s1] && hit_q[eslot_q[idx_s1]] && cmp.id_eq;
	end

	assign snd_wr   = (state_q == S_SENDER) && !(|hit_q);
	assign snd_widx = (scount < (SW+1)'(SENDER_SLOTS)) ? free_s : victim;
	assign ent_wr   = (state_q == S_TAKE) && !(&evalid_q);

	mdd_entry_store u_store (
		.clk      (clk),
		.wr_en    (ent_wr),
		.wr_addr  (free_e),
		.wr_id    (mid_q),
		.wr_ts    (now_q),
		.rd_en    (state_q == S_SWEEP && issue_q),
		.rd_addr  (rd_cnt_q),
		.cmp_id   (mid_q),
		.now      (now_q),
		.lifetime (lifetime_q),
		.cmp      (cmp)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_key;
			mid_q <= message_id;
			now_q <= now_ms;
		end
		if (snd_wr)
			skey_q[snd_widx] <= key_q;
		if (ent_wr)
			eslot_q[free_e] <= sidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			lifetime_q <= 31'(LIFETIME_RESET);
			op_q       <= OP_CHECK;
			hit_q      <= '0;
			sidx_q     <= '0;
			purged_q   <= 1'b0;
			dup_q      <= 1'b0;
			svalid_q   <= '0;
			evalid_q   <= '0;
			for (int s = 0; s < SENDER_SLOTS; s++) srank_q[s] <= '0;
			for (int j = 0; j < MESSAGE_SLOTS; j++) erank_q[j] <= '0;
			rd_cnt_q   <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			live_q     <= '0;
			stale_q    <= '0;
			liverank_q <= '0;
			mask_q     <= '0;
			out_valid_q <= 1'b0;
			out_dup_q  <= 1'b0;
		end else begin
			if (lifetime_we)
				lifetime_q <= lifetime_ms;
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_dup_q   <= dup_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == S_SWEEP) && issue_q;
			idx_s1 <= rd_cnt_q;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= operation;
						hit_q    <= in_hit;
						purged_q <= 1'b0;
						dup_q    <= 1'b0;
						if (operation == OP_RECORD) begin
							state_q <= S_SENDER;
						end else begin
							rd_cnt_q   <= '0;
							issue_q    <= 1'b1;
							live_q     <= '0;
							stale_q    <= '0;
							liverank_q <= '0;
							state_q    <= S_SWEEP;
						end
					end
				end
				S_SENDER: begin
					if (|hit_q) begin
						sidx_q  <= hit_s;
						state_q <= S_TAKE;
					end else if (scount < (SW+1)'(SENDER_SLOTS)) begin
						svalid_q[free_s] <= 1'b1;
						srank_q[free_s]  <= scount[SW-1:0];
						sidx_q  <= free_s;
						state_q <= S_TAKE;
					end else begin
						// evict victim and reuse its slot as the newest sender
						for (int s = 0; s < SENDER_SLOTS; s++)
							if (srank_q[s] > srank_q[victim])
								srank_q[s] <= srank_q[s] - 1'b1;
						srank_q[victim] <= SW'(SENDER_SLOTS - 1);
						sidx_q <= victim;
						for (int j = 0; j < MESSAGE_SLOTS; j++)
							mask_q[j] <= evalid_q[j] && eslot_q[j] == victim;
						ret_q   <= S_TAKE;
						state_q <= S_DROP;
					end
				end
				S_TAKE: begin
					if (!(&evalid_q)) begin
						evalid_q[free_e] <= 1'b1;
						erank_q[free_e]  <= ecount[EW-1:0];
						state_q <= S_DONE;
					end else if (!purged_q) begin
						rd_cnt_q <= '0;
						issue_q  <= 1'b1;
						stale_q  <= '0;
						state_q  <= S_SWEEP;
					end else begin
						for (int j = 0; j < MESSAGE_SLOTS; j++)
							mask_q[j] <= evalid_q[j] && erank_q[j] == '0;
						ret_q   <= S_TAKE;
						state_q <= S_DROP;
					end
				end
				S_SWEEP: begin
					if (issue_q) begin
						if (rd_cnt_q == EW'(MESSAGE_SLOTS - 1))
							issue_q <= 1'b0;
						else
							rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (vld_s1) begin
						if (op_q == OP_CHECK) begin
							live_q[idx_s1]  <= match && !cmp.expired;
							stale_q[idx_s1] <= match && cmp.expired;
							if (match && !cmp.expired)
								liverank_q[erank_q[idx_s1]] <= 1'b1;
						end else begin
							stale_q[idx_s1] <= evalid_q[idx_s1] && cmp.expired;
						end
						if (idx_s1 == EW'(MESSAGE_SLOTS - 1))
							state_q <= S_MASK;
					end
				end
				S_MASK: begin
					if (op_q == OP_CHECK) begin
						// stale matches older than the oldest live match go away; with no live match, all of them go
						for (int j = 0; j < MESSAGE_SLOTS; j++)
							mask_q[j] <= stale_q[j] && (!(|live_q) || erank_q[j] < thr);
						dup_q <= |live_q;
						ret_q <= S_DONE;
					end else begin
						mask_q   <= stale_q;
						purged_q <= 1'b1;
						ret_q    <= S_TAKE;
					end
					state_q <= S_DROP;
				end
				S_DROP: begin
					if (|mask_q) begin
						evalid_q[de] <= 1'b0;
						mask_q[de]   <= 1'b0;
						for (int j = 0; j < MESSAGE_SLOTS; j++)
							if (evalid_q[j] && erank_q[j] > erank_q[de])
								erank_q[j] <= erank_q[j] - 1'b1;
					end else begin
						state_q <= ret_q;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("block idle right after taking an item");

	a_drop_valid_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DROP |-> (mask_q & ~evalid_q) == '0)
		else $error("drop mask names an empty slot");

	a_take_adds_one: assert property (@(posedge clk) disable iff (!arst_n)
		ent_wr |=> $countones(evalid_q) == $countones($past(evalid_q)) + 1)
		else $error("entry append did not add one entry");

	a_senders_keep: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(svalid_q) >= $countones($past(svalid_q)))
		else $error("sender table shrank");
endmodule
